>>> src/ffa_pkg.sv
// Package of shared types, constants and helpers for the first-fit free-list allocator.
package ffa_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int OUT_CNT_W = 11;

    localparam logic [31:0] ROUND_ADD = 32'h0000_0fff;
    localparam logic [31:0] ROUND_MASK = 32'hffff_f000;

    localparam logic [1:0] FUNC_ALLOC = 2'd0;
    localparam logic [1:0] FUNC_FREE = 2'd1;
    localparam logic [1:0] FUNC_ALLOC_4K = 2'd2;
    localparam logic [1:0] FUNC_FREE_4K = 2'd3;

    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_NO_FIT = 2'd1;
    localparam logic [1:0] STATUS_LOST = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_REQ,
        ST_SCAN_CHK,
        ST_PREV,
        ST_APPLY,
        ST_DECIDE,
        ST_SHIFT_DN_REQ,
        ST_SHIFT_DN_WR,
        ST_SHIFT_UP_REQ,
        ST_SHIFT_UP_WR,
        ST_DONE,
        ST_OUT
    } ffa_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture a new item
        logic scan_inc;    // advance scan index
        logic rd_prev;     // read entry below the scan index
        logic apply;       // perform the alloc or free update
        logic sh_dn_rd;    // read entry for a downward move
        logic sh_dn_wr;    // write it one place down
        logic sh_up_rd;    // read entry for an upward move
        logic sh_up_wr;    // write it one place up
        logic finish;      // write final entry and form the result
    } ffa_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_end;    // scan index reached used count
        logic hit;         // current entry stops the scan
        logic need_dn;     // decision needs a downward move
        logic need_up;     // decision needs an upward move
        logic dn_end;
        logic up_end;
    } ffa_stat_t;

endpackage

>>> src/ffa_datapath.sv
// Datapath of the allocator: region table, counters and result registers.
module ffa_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ffa_pkg::ffa_cmd_t             cmd,
    output ffa_pkg::ffa_stat_t            stat,
    input  logic [1:0]                    s_func,
    input  logic [31:0]                   s_region_addr,
    input  logic [31:0]                   s_region_size,
    output logic [31:0]                   m_alloc_addr,
    output logic [1:0]                    m_status,
    output logic [31:0]                   m_free_bytes,
    output logic [10:0]                   m_entries_used,
    output logic [10:0]                   m_entries_peak,
    output logic [31:0]                   m_lost_count,
    output logic [31:0]                   m_lost_bytes
);
    localparam int IW = ffa_pkg::IDX_W;
    localparam int CW = ffa_pkg::CNT_W;

    // Region table: start and length share one address.
    logic [31:0] start_mem [ffa_pkg::TABLE_ENTRIES];
    logic [31:0] len_mem [ffa_pkg::TABLE_ENTRIES];
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] wr_addr;
    logic          wr_en;
    logic [31:0]   wr_start;
    logic [31:0]   wr_len;
    logic [31:0]   rd_start_reg;
    logic [31:0]   rd_len_reg;

    logic          is_free_reg;
    logic [31:0]   addr_reg;
    logic [31:0]   size_reg;
    logic [CW-1:0] k_reg;            // scan index
    logic [CW-1:0] m_reg;            // move index
    logic [CW-1:0] used_reg;
    logic [CW-1:0] peak_reg;
    logic [31:0]   total_reg;
    logic [31:0]   lost_cnt_reg;
    logic [31:0]   lost_bytes_reg;
    logic [31:0]   prev_start_reg;   // entry k-1 on a free
    logic [31:0]   prev_len_reg;
    logic          prev_vld_reg;
    logic [31:0]   cur_start_reg;    // entry k when inside the table
    logic [31:0]   cur_len_reg;
    logic          cur_vld_reg;
    logic          rd_prev_pend_reg;
    logic [1:0]    action_reg;       // 0 none, 1 remove at k, 2 insert at k
    logic [CW-1:0] fin_idx_reg;
    logic [31:0]   fin_start_reg;
    logic [31:0]   fin_len_reg;
    logic          fin_wr_reg;
    logic [31:0]   granted_reg;
    logic [1:0]    status_reg;

    localparam logic [1:0] ACT_NONE = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_INSERT = 2'd2;

    logic [31:0] size_in;
    logic        hit_c;

    // Rounding of the incoming size for the 4K modes.
    always_comb begin
        if (s_func[1]) begin
            size_in = (s_region_size + ffa_pkg::ROUND_ADD) & ffa_pkg::ROUND_MASK;
        end else begin
            size_in = s_region_size;
        end
    end

    // Stop condition for the scan on the entry just read.
    always_comb begin
        if (is_free_reg) begin
            hit_c = rd_start_reg > addr_reg;
        end else begin
            hit_c = rd_len_reg >= size_reg;
        end
    end

    // Memory address and write selection.
    always_comb begin
        rd_addr = k_reg[IW-1:0];
        wr_en = 1'b0;
        wr_addr = m_reg[IW-1:0];
        wr_start = rd_start_reg;
        wr_len = rd_len_reg;
        if (cmd.rd_prev) begin
            rd_addr = IW'(k_reg - CW'(1));
        end
        if (cmd.sh_dn_rd) begin
            rd_addr = IW'(m_reg + CW'(1));
        end
        if (cmd.sh_up_rd) begin
            rd_addr = IW'(m_reg - CW'(1));
        end
        if (cmd.sh_dn_wr || cmd.sh_up_wr) begin
            wr_en = 1'b1;
        end
        if (cmd.finish && fin_wr_reg) begin
            wr_en = 1'b1;
            wr_addr = fin_idx_reg[IW-1:0];
            wr_start = fin_start_reg;
            wr_len = fin_len_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            start_mem[wr_addr] <= wr_start;
            len_mem[wr_addr] <= wr_len;
        end
        rd_start_reg <= start_mem[rd_addr];
        rd_len_reg <= len_mem[rd_addr];
    end

    // Status towards the controller.
    always_comb begin
        stat.scan_end = k_reg == used_reg;
        stat.hit = hit_c;
        stat.need_dn = action_reg == ACT_REMOVE;
        stat.need_up = action_reg == ACT_INSERT;
        stat.dn_end = m_reg >= used_reg;
        stat.up_end = m_reg <= k_reg;
    end

    // Control-state counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
            peak_reg <= '0;
            total_reg <= '0;
            lost_cnt_reg <= '0;
            lost_bytes_reg <= '0;
            k_reg <= '0;
            m_reg <= '0;
            action_reg <= ACT_NONE;
            fin_wr_reg <= 1'b0;
            prev_vld_reg <= 1'b0;
            cur_vld_reg <= 1'b0;
            rd_prev_pend_reg <= 1'b0;
        end else begin
            rd_prev_pend_reg <= cmd.rd_prev;
            if (cmd.load) begin
                is_free_reg <= s_func[0];
                addr_reg <= s_region_addr;
                size_reg <= size_in;
                k_reg <= '0;
                action_reg <= ACT_NONE;
                fin_wr_reg <= 1'b0;
                prev_vld_reg <= 1'b0;
                cur_vld_reg <= 1'b0;
            end
            if (cmd.scan_inc) begin
                k_reg <= k_reg + CW'(1);
            end
            // Latch the hit entry at the scan stop.
            if (cmd.rd_prev) begin
                cur_vld_reg <= !stat.scan_end;
                cur_start_reg <= rd_start_reg;
                cur_len_reg <= rd_len_reg;
            end
            if (rd_prev_pend_reg) begin
                prev_vld_reg <= k_reg != '0;
                prev_start_reg <= rd_start_reg;
                prev_len_reg <= rd_len_reg;
            end
            // Decide on the update for the item.
            if (cmd.apply) begin
                granted_reg <= '0;
                status_reg <= ffa_pkg::STATUS_OK;
                if (!is_free_reg) begin
                    if (!cur_vld_reg) begin
                        status_reg <= ffa_pkg::STATUS_NO_FIT;
                    end else begin
                        granted_reg <= cur_start_reg;
                        total_reg <= total_reg - size_reg;
                        if (cur_len_reg == size_reg) begin
                            action_reg <= ACT_REMOVE;
                            used_reg <= used_reg - CW'(1);
                            m_reg <= k_reg;
                        end else begin
                            fin_wr_reg <= 1'b1;
                            fin_idx_reg <= k_reg;
                            fin_start_reg <= cur_start_reg + size_reg;
                            fin_len_reg <= cur_len_reg - size_reg;
                        end
                    end
                end else if (prev_vld_reg && prev_start_reg + prev_len_reg == addr_reg) begin
                    total_reg <= total_reg + size_reg;
                    fin_wr_reg <= 1'b1;
                    fin_idx_reg <= k_reg - CW'(1);
                    fin_start_reg <= prev_start_reg;
                    if (cur_vld_reg && addr_reg + size_reg == cur_start_reg) begin
                        fin_len_reg <= prev_len_reg + size_reg + cur_len_reg;
                        action_reg <= ACT_REMOVE;
                        used_reg <= used_reg - CW'(1);
                        m_reg <= k_reg;
                    end else begin
                        fin_len_reg <= prev_len_reg + size_reg;
                    end
                end else if (cur_vld_reg && addr_reg + size_reg == cur_start_reg) begin
                    total_reg <= total_reg + size_reg;
                    fin_wr_reg <= 1'b1;
                    fin_idx_reg <= k_reg;
                    fin_start_reg <= addr_reg;
                    fin_len_reg <= cur_len_reg + size_reg;
                end else if (used_reg < CW'(ffa_pkg::TABLE_ENTRIES)) begin
                    total_reg <= total_reg + size_reg;
                    fin_wr_reg <= 1'b1;
                    fin_idx_reg <= k_reg;
                    fin_start_reg <= addr_reg;
                    fin_len_reg <= size_reg;
                    action_reg <= ACT_INSERT;
                    m_reg <= used_reg;
                    used_reg <= used_reg + CW'(1);
                    if (peak_reg < used_reg + CW'(1)) begin
                        peak_reg <= used_reg + CW'(1);
                    end
                end else begin
                    status_reg <= ffa_pkg::STATUS_LOST;
                    lost_cnt_reg <= lost_cnt_reg + 32'd1;
                    lost_bytes_reg <= lost_bytes_reg + size_reg;
                end
            end
            if (cmd.sh_dn_wr) begin
                m_reg <= m_reg + CW'(1);
            end
            if (cmd.sh_up_wr) begin
                m_reg <= m_reg - CW'(1);
            end
            if (cmd.finish) begin
                action_reg <= ACT_NONE;
            end
        end
    end

    // Result registers, loaded once the table update is complete.
    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_alloc_addr <= granted_reg;
            m_status <= status_reg;
            m_free_bytes <= total_reg;
            m_entries_used <= ffa_pkg::OUT_CNT_W'(used_reg);
            m_entries_peak <= ffa_pkg::OUT_CNT_W'(peak_reg);
            m_lost_count <= lost_cnt_reg;
            m_lost_bytes <= lost_bytes_reg;
        end
    end

endmodule

>>> src/ffa_ctrl.sv
// Controller state machine sequencing scan, update and table moves.
module ffa_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  ffa_pkg::ffa_stat_t stat,
    output ffa_pkg::ffa_cmd_t  cmd
);
    ffa_pkg::ffa_state_t state_reg;
    ffa_pkg::ffa_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ffa_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ffa_pkg::ST_IDLE: begin
                if (s_valid) state_next = ffa_pkg::ST_SCAN_REQ;
            end
            ffa_pkg::ST_SCAN_REQ: state_next = ffa_pkg::ST_SCAN_CHK;
            ffa_pkg::ST_SCAN_CHK: begin
                if (stat.scan_end || stat.hit) state_next = ffa_pkg::ST_PREV;
                else state_next = ffa_pkg::ST_SCAN_REQ;
            end
            ffa_pkg::ST_PREV: state_next = ffa_pkg::ST_APPLY;
            ffa_pkg::ST_APPLY: state_next = ffa_pkg::ST_DECIDE;
            ffa_pkg::ST_DECIDE: begin
                if (stat.need_dn) state_next = ffa_pkg::ST_SHIFT_DN_REQ;
                else if (stat.need_up) state_next = ffa_pkg::ST_SHIFT_UP_REQ;
                else state_next = ffa_pkg::ST_DONE;
            end
            ffa_pkg::ST_SHIFT_DN_REQ: begin
                if (stat.dn_end) state_next = ffa_pkg::ST_DONE;
                else state_next = ffa_pkg::ST_SHIFT_DN_WR;
            end
            ffa_pkg::ST_SHIFT_DN_WR: state_next = ffa_pkg::ST_SHIFT_DN_REQ;
            ffa_pkg::ST_SHIFT_UP_REQ: begin
                if (stat.up_end) state_next = ffa_pkg::ST_DONE;
                else state_next = ffa_pkg::ST_SHIFT_UP_WR;
            end
            ffa_pkg::ST_SHIFT_UP_WR: state_next = ffa_pkg::ST_SHIFT_UP_REQ;
            ffa_pkg::ST_DONE: state_next = ffa_pkg::ST_OUT;
            ffa_pkg::ST_OUT: begin
                if (m_ready) state_next = ffa_pkg::ST_IDLE;
            end
            default: state_next = ffa_pkg::ST_IDLE;
        endcase
    end

    // Outputs. The read of the entry below lands in the previous-entry state,
    // apply follows, and the decide state then branches on the chosen action.
    always_comb begin
        cmd = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        unique case (state_reg)
            ffa_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                cmd.load = s_valid;
            end
            ffa_pkg::ST_SCAN_REQ, ffa_pkg::ST_PREV, ffa_pkg::ST_DECIDE: cmd = '0;
            ffa_pkg::ST_SCAN_CHK: begin
                if (stat.scan_end || stat.hit) cmd.rd_prev = 1'b1;
                else cmd.scan_inc = 1'b1;
            end
            ffa_pkg::ST_APPLY: cmd.apply = 1'b1;
            ffa_pkg::ST_SHIFT_DN_REQ: cmd.sh_dn_rd = 1'b1;
            ffa_pkg::ST_SHIFT_DN_WR: cmd.sh_dn_wr = 1'b1;
            ffa_pkg::ST_SHIFT_UP_REQ: cmd.sh_up_rd = 1'b1;
            ffa_pkg::ST_SHIFT_UP_WR: cmd.sh_up_wr = 1'b1;
            ffa_pkg::ST_DONE: cmd.finish = 1'b1;
            ffa_pkg::ST_OUT: m_valid = 1'b1;
            default: cmd = '0;
        endcase
    end

endmodule

>>> src/first_fit_free_list_allocator.sv
// First-fit free-list allocator: the top level joining controller and datapath.
//
// Each item takes a table scan, one entry at a time on one memory read port,
// then a read of the entry below and a decision, and for a removal or an
// insertion a move of each entry behind the hit position by one place.
// Scan and moves together cover the table about once. The result waits in its
// output registers until taken, and the next item is accepted after that.
module first_fit_free_list_allocator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [31:0] s_region_addr,
    input  logic [31:0] s_region_size,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_alloc_addr,
    output logic [1:0]  m_status,
    output logic [31:0] m_free_bytes,
    output logic [10:0] m_entries_used,
    output logic [10:0] m_entries_peak,
    output logic [31:0] m_lost_count,
    output logic [31:0] m_lost_bytes
);
    ffa_pkg::ffa_cmd_t  cmd;
    ffa_pkg::ffa_stat_t stat;

    ffa_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready),
        .stat(stat), .cmd(cmd)
    );

    ffa_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .s_func(s_func), .s_region_addr(s_region_addr), .s_region_size(s_region_size),
        .m_alloc_addr(m_alloc_addr), .m_status(m_status), .m_free_bytes(m_free_bytes),
        .m_entries_used(m_entries_used), .m_entries_peak(m_entries_peak),
        .m_lost_count(m_lost_count), .m_lost_bytes(m_lost_bytes)
    );

endmodule

>>> src/ffa_checker.sv
// Port-level assertions for the allocator and their bind to the top level.
module ffa_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_status,
    input logic [10:0] m_entries_used,
    input logic [10:0] m_entries_peak,
    input logic [31:0] m_alloc_addr
);
    // One item at a time: no new item while a result is shown.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input ready while result pending");

    // The peak never falls below the current use.
    a_peak: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_entries_peak >= m_entries_used) else $error("peak below use");

    // A failed item grants address zero.
    a_addr_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ffa_pkg::STATUS_OK) |-> m_alloc_addr == 32'd0)
        else $error("nonzero address on failure");

    // A waiting result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_status)))
        else $error("result changed while stalled");

endmodule

bind first_fit_free_list_allocator ffa_checker u_ffa_checker (
    .aclk(aclk), .aresetn(aresetn), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
    .m_entries_used(m_entries_used), .m_entries_peak(m_entries_peak),
    .m_alloc_addr(m_alloc_addr)
);
